[src/sorted_set_table_assert.svh]
// Assertion macros for the sorted set table.
// Depends on nothing; included by the top level only.
`ifndef SORTED_SET_TABLE_ASSERT_SVH
`define SORTED_SET_TABLE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define SST_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sorted_set_table: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define SST_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sorted_set_table: next-cycle check failed");

`endif

[src/sst_pkg.sv]
// Shared types and constants for the sorted set table.
// No dependencies; used by the interfaces, the cell and the top level.
package sst_pkg;

    localparam int CAPACITY  = 64;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int VAL_W     = 32;
    localparam int IDX_W     = 6;
    localparam int OUT_CNT_W = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_READ   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_NOCHG = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POST
    } t_state;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic capture;
        logic insert;
        logic remove;
    } t_cell_cmd;

endpackage

[src/sst_if.sv]
// Request and response channels of the sorted set table.
// Depends on sst_pkg.
interface sst_req_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          opcode;
    logic signed [sst_pkg::VAL_W-1:0]    value;
    logic [sst_pkg::IDX_W-1:0]           entry_index;

    modport source (output valid, opcode, value, entry_index, input ready);
    modport sink   (input valid, opcode, value, entry_index, output ready);
endinterface

interface sst_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                found;
    logic [1:0]                          status;
    logic [sst_pkg::OUT_CNT_W-1:0]       entry_count;
    logic signed [sst_pkg::VAL_W-1:0]    min_value;
    logic signed [sst_pkg::VAL_W-1:0]    max_value;
    logic signed [sst_pkg::VAL_W-1:0]    entry_value;

    modport source (output valid, found, status, entry_count, min_value, max_value,
                    entry_value, input ready);
    modport sink   (input valid, found, status, entry_count, min_value, max_value,
                    entry_value, output ready);
endinterface

[src/sst_cell.sv]
// One storage cell of the sorted row: holds one entry and its compare flags.
// Depends on sst_pkg.
module sst_cell (
    input  logic                             i_clk,
    input  sst_pkg::t_cell_cmd               i_cmd,
    input  logic                             i_valid,
    input  logic signed [sst_pkg::VAL_W-1:0] i_key,
    input  logic signed [sst_pkg::VAL_W-1:0] i_left_value,
    input  logic                             i_left_lt,
    input  logic signed [sst_pkg::VAL_W-1:0] i_right_value,
    output logic signed [sst_pkg::VAL_W-1:0] o_value,
    output logic                             o_lt,
    output logic                             o_eq
);
    import sst_pkg::*;

    logic signed [VAL_W-1:0] r_value, n_value;
    logic                    r_lt, n_lt;
    logic                    r_eq, n_eq;

    always_comb begin
        n_lt    = r_lt;
        n_eq    = r_eq;
        n_value = r_value;
        if (i_cmd.capture) begin
            n_lt = i_valid && (r_value < i_key);
            n_eq = i_valid && (r_value == i_key);
        end
        // cells at or above the insert point move up; the boundary cell takes the key
        if (i_cmd.insert && !r_lt) begin
            n_value = i_left_lt ? i_key : i_left_value;
        end else if (i_cmd.remove && !r_lt) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_lt    <= n_lt;
        r_eq    <= n_eq;
    end

    assign o_value = r_value;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

[src/sorted_set_table.sv]
// Sorted set table: top level. A row of CAPACITY cells holds distinct signed
// values in ascending order.
// Depends on sst_pkg, sst_if, sst_cell and sorted_set_table_assert.svh.
//
// Each request (insert, remove, lookup, read at index) is handled in two steps in the
// row: in the accept cycle every cell compares its entry with the request
// value, and in the next cycle the control decides and all cells at or above
// the insert point shift one place up (insert) or down (remove) at once. The
// response register then loads from the updated row in state S_POST, and that
// same cycle may accept the next request, so a new request is taken only once
// the previous one has reached the response load. A response that is not taken
// holds the row in its final step and stops new requests. Every response carries
// the count, minimum and maximum after the request (0 for an empty set). The
// store needs no clearing after reset: only entries below the count are ever
// looked at.
module sorted_set_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sst_req_if.sink    i_req,
    sst_rsp_if.source  o_rsp
);
    import sst_pkg::*;

    `include "sorted_set_table_assert.svh"

    // request held for the decision cycle
    t_opcode               r_op;
    logic signed [VAL_W-1:0] r_val;
    logic [IDX_W-1:0]      r_idx;

    // control state
    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_found, n_found;
    t_status               r_status, n_status;

    // response register
    logic                  r_out_valid;
    logic                  r_out_found;
    t_status               r_out_status;
    logic [OUT_CNT_W-1:0]  r_out_count;
    logic signed [VAL_W-1:0] r_out_min, r_out_max, r_out_ev;

    // row wiring
    t_cell_cmd             cell_cmd;
    logic signed [VAL_W-1:0] key;
    logic signed [VAL_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]   cell_lt;
    logic [CAPACITY-1:0]   cell_eq;
    logic [CAPACITY-1:0]   cell_valid;

    logic                  accept;
    logic                  in_ready;
    logic                  out_free;
    logic                  out_load;
    logic                  present;
    logic                  full;
    logic                  read_ok;
    logic signed [VAL_W-1:0] max_sel, ev_sel;

    assign out_free = !r_out_valid || o_rsp.ready;
    assign accept   = i_req.valid && in_ready;
    assign present  = |cell_eq;
    assign full     = (r_count == CNT_W'(CAPACITY));
    assign read_ok  = (32'(r_idx) < 32'(r_count));

    // ---------------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        n_state          = r_state;
        in_ready         = 1'b0;
        out_load         = 1'b0;
        cell_cmd         = '0;
        unique case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_req.valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                cell_cmd.insert = (r_op == OP_INSERT) && !present && !full;
                cell_cmd.remove = (r_op == OP_REMOVE) && present;
                n_state         = S_POST;
            end
            S_POST: begin
                if (out_free) begin
                    out_load = 1'b1;
                    in_ready = 1'b1;
                    n_state  = i_req.valid ? S_EXEC : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        cell_cmd.capture = i_req.valid && in_ready;
    end

    assign key = cell_cmd.capture ? i_req.value : r_val;

    // decision: found, status and new count
    always_comb begin
        n_found  = r_found;
        n_status = r_status;
        n_count  = r_count;
        if (r_state == S_EXEC) begin
            n_found  = 1'b0;
            n_status = ST_DONE;
            unique case (r_op)
                OP_INSERT: begin
                    if (present) begin
                        n_found  = 1'b1;
                        n_status = ST_NOCHG;
                    end else if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
                OP_REMOVE: begin
                    if (present) begin
                        n_found = 1'b1;
                        n_count = r_count - CNT_W'(1);
                    end else begin
                        n_status = ST_NOCHG;
                    end
                end
                OP_LOOKUP: begin
                    n_found  = present;
                    n_status = present ? ST_DONE : ST_NOCHG;
                end
                OP_READ: begin
                    n_found  = read_ok;
                    n_status = read_ok ? ST_DONE : ST_NOCHG;
                end
                default: n_status = ST_NOCHG;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_found  <= n_found;
        r_status <= n_status;
        if (accept) begin
            r_op  <= t_opcode'(i_req.opcode);
            r_val <= i_req.value;
            r_idx <= i_req.entry_index;
        end
    end

    // ---------------------------------------------------------------------
    // row of cells
    // ---------------------------------------------------------------------
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VAL_W-1:0] left_value;
        logic signed [VAL_W-1:0] right_value;
        logic                    left_lt;

        assign cell_valid[g] = (32'(g) < 32'(r_count));

        if (g == 0) begin : g_first
            assign left_value = cell_value[g];
            assign left_lt    = 1'b1;     // bottom cell is the insert point when nothing is below
        end else begin : g_inner
            assign left_value = cell_value[g-1];
            assign left_lt    = cell_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_value = cell_value[g];
        end else begin : g_body
            assign right_value = cell_value[g+1];
        end

        sst_cell u_cell (
            .i_clk         (i_clk),
            .i_cmd         (cell_cmd),
            .i_valid       (cell_valid[g]),
            .i_key         (key),
            .i_left_value  (left_value),
            .i_left_lt     (left_lt),
            .i_right_value (right_value),
            .o_value       (cell_value[g]),
            .o_lt          (cell_lt[g]),
            .o_eq          (cell_eq[g])
        );
    end

    // top entry and indexed entry, picked by each cell's own position match
    always_comb begin
        max_sel = '0;
        ev_sel  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if ((i + 1) == int'(r_count)) max_sel = max_sel | cell_value[i];
            if (i == int'(r_idx))         ev_sel  = ev_sel  | cell_value[i];
        end
    end

    // ---------------------------------------------------------------------
    // response register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_found  <= r_found;
            r_out_status <= r_status;
            r_out_count  <= OUT_CNT_W'(r_count);
            r_out_min    <= (r_count != '0) ? cell_value[0] : '0;
            r_out_max    <= max_sel;
            r_out_ev     <= ((r_op == OP_READ) && r_found) ? ev_sel : '0;
        end
    end

    assign i_req.ready       = in_ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_out_found;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.entry_count = r_out_count;
    assign o_rsp.min_value   = r_out_min;
    assign o_rsp.max_value   = r_out_max;
    assign o_rsp.entry_value = r_out_ev;

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    `SST_ASSERT_NOW(a_no_accept_in_exec, i_clk, i_rst_n, r_state == S_EXEC, !i_req.ready)
    `SST_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, cell_cmd.insert, r_count == $past(r_count) + CNT_W'(1))
    `SST_ASSERT_NEXT(a_remove_shrinks, i_clk, i_rst_n, cell_cmd.remove, r_count == $past(r_count) - CNT_W'(1))
    `SST_ASSERT_NOW(a_full_only_at_cap, i_clk, i_rst_n, o_rsp.valid && (o_rsp.status == ST_FULL), o_rsp.entry_count == OUT_CNT_W'(CAPACITY))

endmodule
